// ----- src/u2pf_pkg.sv -----
`default_nettype none

package u2pf_pkg;

  // Frame layout and character codes.
  localparam logic [8:0] FRAME_HEAD   = 9'd466;
  localparam int         CHECK_BIAS   = 200;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam logic [7:0] UNKNOWN_CODE = 8'd63;
  localparam logic [7:0] IO_CODE      = 8'd133;

  // UTF-8 decoding of the two-byte Cyrillic range.
  localparam logic [6:0] LEAD_HI      = 7'h68;  // 0xD0 and 0xD1 share these bits
  localparam logic [7:0] CYR_FIRST    = 8'h90;
  localparam logic [7:0] CYR_LAST     = 8'hAF;
  localparam logic [7:0] CYR_OFFSET   = 8'd16;  // 0x90 lands on code 128
  localparam logic [7:0] IO_SECOND    = 8'h81;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;     // an input byte is accepted this cycle
    logic last;     // the accepted byte ends the string
    logic load;     // load the next frame word into the output register
    logic clr_cnt;  // text frame done, forget the kept characters
    logic text;     // the word belongs to the text frame
  } u2pf_cmd_t;

endpackage

`default_nettype wire

// ----- src/utf8_text_to_panel_frame_top.sv -----
// Text bytes are taken one per cycle; a byte without tlast causes no output.
// After the byte with tlast, the emit state loads the first frame word, and
// the clear and text frames follow at one word per cycle, 2*(TEXT_CHARS+5)
// words in all, paced by the output register; no byte is taken meanwhile.
// Reset (rst_n low, synchronous) clears the decoder, character count and
// sequencer; the character store keeps its contents and is never read stale.
`default_nettype none

module utf8_text_to_panel_frame_top
  import u2pf_pkg::*;
#(
  parameter int TEXT_CHARS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tlast,   // in_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [8:0] frame_word, [15:9] zero
  output logic             out_tlast,  // frame_end
  output logic             out_tuser   // run_last
);

  localparam int IDXW = $clog2(TEXT_CHARS + 5);

  u2pf_cmd_t       cmd;
  logic [IDXW-1:0] idx;
  logic [8:0]      word;

  u2pf_ctrl #(
    .TEXT_CHARS (TEXT_CHARS),
    .IDXW       (IDXW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .idx_r      (idx)
  );

  u2pf_datapath #(
    .TEXT_CHARS (TEXT_CHARS),
    .IDXW       (IDXW)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .idx     (idx),
    .in_byte (in_tdata),
    .word_r  (word)
  );

  assign out_tdata = {7'd0, word};

endmodule

`default_nettype wire

// ----- src/u2pf_datapath.sv -----
`default_nettype none

module u2pf_datapath
  import u2pf_pkg::*;
#(
  parameter int TEXT_CHARS = 10,
  parameter int IDXW       = $clog2(TEXT_CHARS + 5)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire u2pf_cmd_t       cmd,
  input  wire logic [IDXW-1:0] idx,
  input  wire logic [7:0]      in_byte,
  output logic [8:0]           word_r
);

  localparam int CW    = $clog2(TEXT_CHARS + 1);
  localparam int IW    = (TEXT_CHARS > 1) ? $clog2(TEXT_CHARS) : 1;
  localparam int SUM_W = $clog2(TEXT_CHARS * 256 + 256 + CHECK_BIAS);

  logic          lead_r, lead_nxt;
  logic          d1_r, d1_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    store_r [TEXT_CHARS];
  logic [SUM_W-1:0] sum_r, sum_nxt;

  logic       room, is_ascii, is_lead, keep;
  logic [7:0] keep_code, pair_code;

  // Decode the incoming byte.
  assign room     = (count_r < CW'(TEXT_CHARS));
  assign is_ascii = (in_byte != 8'd0) && !in_byte[7];
  assign is_lead  = (in_byte[7:1] == LEAD_HI);

  // Map the second byte of a pair to a panel code.
  always_comb begin
    if (!d1_r && in_byte >= CYR_FIRST && in_byte <= CYR_LAST) begin
      pair_code = in_byte - CYR_OFFSET;
    end else if (!d1_r && in_byte == IO_SECOND) begin
      pair_code = IO_CODE;
    end else begin
      pair_code = UNKNOWN_CODE;
    end
  end

  // Character intake: pairs, plain ASCII and a dangling lead at the end.
  always_comb begin
    lead_nxt  = lead_r;
    d1_nxt    = d1_r;
    keep      = 1'b0;
    keep_code = in_byte;
    if (cmd.take && room) begin
      priority if (lead_r) begin
        keep      = 1'b1;
        keep_code = pair_code;
        lead_nxt  = 1'b0;
        d1_nxt    = 1'b0;
      end else if (is_ascii) begin
        keep = 1'b1;
      end else if (is_lead && cmd.last) begin
        keep      = 1'b1;
        keep_code = UNKNOWN_CODE;
      end else if (is_lead) begin
        lead_nxt = 1'b1;
        d1_nxt   = in_byte[0];
      end else begin
        // Any other byte is skipped.
        keep = 1'b0;
      end
    end
    if (cmd.take && cmd.last) begin
      lead_nxt = 1'b0;
      d1_nxt   = 1'b0;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.clr_cnt) begin
      count_nxt = '0;
    end else if (keep) begin
      count_nxt = count_r + CW'(1);
    end
  end

  // Frame word selection; slots are read back in reverse order.
  logic [IDXW-1:0] src;
  logic [7:0]      slot;
  logic [SUM_W-1:0] sum_biased;
  logic [8:0]      word_nxt;

  assign src        = IDXW'(TEXT_CHARS + 2) - idx;
  assign slot       = (cmd.text && (CW'(src) < count_r)) ? store_r[src[IW-1:0]] : SPACE_CODE;
  assign sum_biased = sum_r + SUM_W'(CHECK_BIAS);

  always_comb begin
    priority if (idx == IDXW'(0)) begin
      word_nxt = FRAME_HEAD;
    end else if (idx == IDXW'(1)) begin
      word_nxt = 9'd1;
    end else if (idx == IDXW'(2)) begin
      word_nxt = 9'(TEXT_CHARS);
    end else if (idx == IDXW'(TEXT_CHARS + 3)) begin
      word_nxt = 9'(sum_biased >> 8);
    end else if (idx == IDXW'(TEXT_CHARS + 4)) begin
      word_nxt = {1'b0, sum_biased[7:0]};
    end else begin
      word_nxt = {1'b0, slot};
    end
  end

  // Running check sum over words one through TEXT_CHARS+2.
  always_comb begin
    sum_nxt = sum_r;
    if (cmd.load) begin
      if (idx == IDXW'(0)) begin
        sum_nxt = '0;
      end else if (idx <= IDXW'(TEXT_CHARS + 2)) begin
        sum_nxt = sum_r + SUM_W'(word_nxt);
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r  <= 1'b0;
      d1_r    <= 1'b0;
      count_r <= '0;
    end else begin
      lead_r  <= lead_nxt;
      d1_r    <= d1_nxt;
      count_r <= count_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (keep) begin
      store_r[count_r[IW-1:0]] <= keep_code;
    end
    sum_r <= sum_nxt;
    if (cmd.load) begin
      word_r <= word_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/u2pf_ctrl.sv -----
`default_nettype none

module u2pf_ctrl
  import u2pf_pkg::*;
#(
  parameter int TEXT_CHARS = 10,
  parameter int IDXW       = $clog2(TEXT_CHARS + 5)
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  input  wire logic       in_tlast,
  output logic            in_tready,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic            out_tlast,
  output logic            out_tuser,
  output u2pf_cmd_t       cmd,
  output logic [IDXW-1:0] idx_r
);

  typedef enum logic {ST_TEXT, ST_EMIT} state_t;

  state_t          state_r, state_nxt;
  logic [IDXW-1:0] idx_nxt;
  logic            text_r, text_nxt;
  logic            valid_r, valid_nxt;
  logic            last_r, last_nxt;
  logic            user_r, user_nxt;
  logic            advance, final_word;

  assign in_tready  = (state_r == ST_TEXT);
  assign out_tvalid = valid_r;
  assign out_tlast  = last_r;
  assign out_tuser  = user_r;

  assign advance    = (state_r == ST_EMIT) && (!valid_r || out_tready);
  assign final_word = (idx_r == IDXW'(TEXT_CHARS + 4));

  // Commands for the datapath.
  always_comb begin
    cmd.take    = in_tvalid && in_tready;
    cmd.last    = in_tlast;
    cmd.load    = advance;
    cmd.clr_cnt = advance && final_word && text_r;
    cmd.text    = text_r;
  end

  // Sequencing of the two frames.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    text_nxt  = text_r;
    valid_nxt = valid_r && !out_tready;
    last_nxt  = last_r;
    user_nxt  = user_r;
    unique case (state_r)
      ST_TEXT: begin
        if (in_tvalid && in_tlast) begin
          state_nxt = ST_EMIT;
          idx_nxt   = '0;
          text_nxt  = 1'b0;
        end
      end
      ST_EMIT: begin
        if (advance) begin
          valid_nxt = 1'b1;
          last_nxt  = final_word;
          user_nxt  = final_word && text_r;
          if (final_word) begin
            idx_nxt  = '0;
            text_nxt = 1'b1;
            if (text_r) begin
              state_nxt = ST_TEXT;
            end
          end else begin
            idx_nxt = idx_r + IDXW'(1);
          end
        end
      end
      default: state_nxt = ST_TEXT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_TEXT;
      idx_r   <= '0;
      text_r  <= 1'b0;
      valid_r <= 1'b0;
      last_r  <= 1'b0;
      user_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      text_r  <= text_nxt;
      valid_r <= valid_nxt;
      last_r  <= last_nxt;
      user_r  <= user_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/u2pf_checker.sv -----
`default_nettype none

module u2pf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic        out_tuser
);

  // The end of the text frame is always also the end of a frame.
  a_user_in_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("run_last without frame_end");

  // Frame words are nine bits wide.
  a_word_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:9] == 7'd0))
    else $error("frame word wider than nine bits");

  // Input is held off right after the last byte of a string is taken.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input taken right after the last byte");

  // A stalled output transaction keeps its word.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output changed");

endmodule

bind utf8_text_to_panel_frame_top u2pf_checker u_checker (.*);

`default_nettype wire

// ----- dv/panel_frame_checker.sv -----
`timescale 1ns / 1ps

// Watches both stream channels of the text-to-panel-frame block, predicts the
// clear and text frames for every string and compares each output word.
module panel_frame_checker
  import u2pf_pkg::*;
#(
  parameter int TEXT_CHARS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tlast,   // in_last
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [15:0] out_tdata,  // [8:0] frame_word, [15:9] zero
  input  wire logic        out_tlast,  // frame_end
  input  wire logic        out_tuser,  // run_last
  output int               fail_count,
  output int               pending
);

  localparam int FRAME_WORDS = TEXT_CHARS + 5;
  localparam int REPORT_LIMIT = 10;
  localparam logic [7:0] LEAD_D0 = 8'hD0;
  localparam logic [7:0] LEAD_D1 = 8'hD1;

  typedef struct packed {
    logic [8:0] word;
    logic       frame_end;
    logic       run_last;
  } panel_word_t;

  // Decoder state of the string being collected.
  logic        lead_pending;
  logic        lead_d1;
  int          kept_count;
  logic [7:0]  kept_chars [TEXT_CHARS];
  panel_word_t expected_words [$];

  // Character code for a two-byte sequence.
  function automatic logic [7:0] pair_code(logic d1, logic [7:0] second);
    if (!d1 && second >= CYR_FIRST && second <= CYR_LAST) return second - CYR_OFFSET;
    if (!d1 && second == IO_SECOND) return IO_CODE;
    return UNKNOWN_CODE;
  endfunction

  task automatic keep_char(logic [7:0] code);
    if (kept_count < TEXT_CHARS) begin
      kept_chars[kept_count] = code;
      kept_count++;
    end
  endtask

  // One text byte; nothing changes once the store is full.
  task automatic take_byte(logic [7:0] b);
    if (kept_count >= TEXT_CHARS) return;
    if (lead_pending) begin
      keep_char(pair_code(lead_d1, b));
      lead_pending = 1'b0;
      lead_d1 = 1'b0;
    end else if (b >= 8'h01 && b < 8'h80) begin
      keep_char(b);
    end else if (b == LEAD_D0 || b == LEAD_D1) begin
      lead_pending = 1'b1;
      lead_d1 = (b == LEAD_D1);
    end
  endtask

  // Builds one frame with its check words and queues it.
  task automatic queue_frame(logic text);
    logic [8:0]  words [FRAME_WORDS];
    int unsigned sum;
    int          i;
    int          src;
    panel_word_t w;
    words[0] = FRAME_HEAD;
    words[1] = 9'd1;
    words[2] = 9'(TEXT_CHARS);
    for (i = 0; i < TEXT_CHARS; i++) begin
      src = TEXT_CHARS - 1 - i;
      words[3 + i] = (text && src < kept_count) ? {1'b0, kept_chars[src]} : {1'b0, SPACE_CODE};
    end
    sum = CHECK_BIAS;
    for (i = 1; i <= TEXT_CHARS + 2; i++) sum += words[i];
    words[TEXT_CHARS + 3] = 9'((sum >> 8) & 32'h1FF);
    words[TEXT_CHARS + 4] = 9'(sum & 32'hFF);
    for (i = 0; i < FRAME_WORDS; i++) begin
      w.word = words[i];
      w.frame_end = (i == FRAME_WORDS - 1);
      w.run_last = w.frame_end && text;
      expected_words.push_back(w);
    end
  endtask

  // The last byte closes a dangling lead byte and releases both frames.
  task automatic end_string();
    if (lead_pending) keep_char(pair_code(lead_d1, 8'h00));
    queue_frame(1'b0);
    queue_frame(1'b1);
    lead_pending = 1'b0;
    lead_d1 = 1'b0;
    kept_count = 0;
  endtask

  task automatic check_word();
    panel_word_t exp;
    if (expected_words.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("%0t: unexpected frame word: tdata=%0d tlast=%0b tuser=%0b",
                 $realtime, out_tdata, out_tlast, out_tuser);
    end else begin
      exp = expected_words.pop_front();
      if (out_tdata !== {7'd0, exp.word} || out_tlast !== exp.frame_end ||
          out_tuser !== exp.run_last) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("%0t: frame word mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                   $realtime, exp.word, exp.frame_end, exp.run_last,
                   out_tdata, out_tlast, out_tuser);
      end
    end
  endtask

  // Output transactions are checked before a new string adds expectations.
  always @(posedge clk) begin
    if (!rst_n) begin
      lead_pending = 1'b0;
      lead_d1 = 1'b0;
      kept_count = 0;
      fail_count = 0;
      expected_words.delete();
    end else begin
      if (out_tvalid === 1'b1 && out_tready === 1'b1) check_word();
      if (in_tvalid === 1'b1 && in_tready === 1'b1) begin
        take_byte(in_tdata);
        if (in_tlast) end_string();
      end
    end
    pending = expected_words.size();
  end

endmodule

// ----- dv/utf8_text_to_panel_frame_top_tb.sv -----
`timescale 1ns / 1ps

module utf8_text_to_panel_frame_top_tb
  import u2pf_pkg::*;
();

  localparam int TEXT_CHARS = 10;
  localparam int RANDOM_ITEMS = 80;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [7:0] LEAD_D0 = 8'hD0;
  localparam logic [7:0] LEAD_D1 = 8'hD1;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_byte_t;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_MOSTLY} stall_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] in_byte
  logic        in_tlast;   // in_last
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [8:0] frame_word, [15:9] zero
  logic        out_tlast;  // frame_end
  logic        out_tuser;  // run_last

  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          burst_left;
  bit          steady;
  text_byte_t  text_bytes [$];

  utf8_text_to_panel_frame_top #(.TEXT_CHARS(TEXT_CHARS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  panel_frame_checker #(.TEXT_CHARS(TEXT_CHARS)) frame_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic put(logic [7:0] b);
    text_byte_t item;
    item.data = b;
    item.last = 1'b0;
    text_bytes.push_back(item);
  endtask

  // Flags the final queued byte as the end of the string.
  task automatic close_string();
    text_byte_t item;
    item = text_bytes.pop_back();
    item.last = 1'b1;
    text_bytes.push_back(item);
  endtask

  // Sends the string in bursts unless steady; valid stays high within a burst.
  task automatic send_string();
    text_byte_t item;
    while (text_bytes.size() > 0) begin
      item = text_bytes.pop_front();
      in_tvalid <= 1'b1;
      in_tdata <= item.data;
      in_tlast <= item.last;
      @(posedge clk);
      while (in_tready !== 1'b1) @(posedge clk);
      @(negedge clk);
      if (!steady) begin
        burst_left--;
        if (burst_left <= 0) begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(negedge clk);
          burst_left = $urandom_range(1, 10);
        end
      end
    end
  endtask

  // Holds the sender until every predicted word has been seen.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // A string of mostly well-formed characters with some noise bytes mixed in.
  task automatic build_random_string();
    int chars;
    int pick;
    chars = $urandom_range(1, 13);
    repeat (chars) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        put(8'($urandom_range(1, 127)));
      end else if (pick < 60) begin
        put(LEAD_D0);
        put(8'($urandom_range(CYR_FIRST, CYR_LAST)));
      end else if (pick < 65) begin
        put(LEAD_D0);
        put(IO_SECOND);
      end else if (pick < 72) begin
        put(LEAD_D1);
        put(8'($urandom_range(0, 255)));
      end else if (pick < 80) begin
        put(LEAD_D0);
        put(8'($urandom_range(0, 255)));
      end else begin
        put(8'($urandom_range(0, 255)));
      end
    end
    // Sometimes the string ends on a lead byte with no partner.
    if ($urandom_range(0, 7) == 0) put($urandom_range(0, 1) ? LEAD_D0 : LEAD_D1);
    close_string();
  endtask

  // Receiver: one long hold-off on the first frame, then changing stall patterns.
  initial begin
    stall_mode_t mode;
    int          span;
    out_tready = 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1 || out_tvalid !== 1'b1) @(posedge clk);
    @(negedge clk);
    repeat (LONG_HOLD) @(negedge clk);
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(5, 60);
      repeat (span) begin
        case (mode)
          READY_ALWAYS: out_tready <= 1'b1;
          READY_COIN:   out_tready <= 1'($urandom_range(0, 1));
          READY_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
          default:      out_tready <= ($urandom_range(0, 7) != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int items;
    int i;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tlast = 1'b0;
    rst_n = 1'b0;
    burst_left = 4;
    steady = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ASCII extremes, a zero byte, a skipped byte, the Cyrillic range ends,
    // the Io letter and a pair outside the range.
    put(8'h01); put(8'h7F); put(8'h00); put(8'hFF);
    put(LEAD_D0); put(CYR_FIRST);
    put(LEAD_D0); put(CYR_LAST);
    put(LEAD_D0); put(IO_SECOND);
    put(LEAD_D0); put(8'h8F);
    close_string();
    send_string();

    // Lead byte followed by a lead byte, then a lead byte flagged last.
    put(LEAD_D0); put(LEAD_D1); put(8'h41); put(LEAD_D1);
    close_string();
    send_string();

    // A full store ignores a trailing lead byte.
    for (i = 0; i < TEXT_CHARS; i++) put(8'h61 + 8'(i));
    put(LEAD_D1);
    close_string();
    send_string();

    // A string that keeps no character at all.
    put(8'h80);
    close_string();
    send_string();
    drain_results();

    items = 0;
    while (items < RANDOM_ITEMS) begin
      build_random_string();
      items += text_bytes.size();
      steady = ($urandom_range(0, 3) == 0);
      send_string();
      if ($urandom_range(0, 4) == 0) drain_results();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
